// File: rtl/lrup_pkg.sv
`timescale 1ns / 1ps

package lrup_pkg;

  // Default frame count of the store
  localparam int FRAMES_DEF = 8;

  // Page number width
  localparam int PAGE_BITS = 16;

  // Config register width and reset value
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] FIU_RESET = 4'd8;

  // Result field widths
  localparam int IDX_OUT_W = 3;
  localparam int CNT_W = 32;

endpackage

// File: rtl/lrup_if.sv
`timescale 1ns / 1ps

// Page reference channel
interface lrup_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrup_pkg::PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

// Result channel
interface lrup_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fault;
  logic [lrup_pkg::IDX_OUT_W-1:0] frame_index;
  logic                          evicted_valid;
  logic [lrup_pkg::PAGE_BITS-1:0] evicted_page;
  logic [lrup_pkg::CNT_W-1:0]     fault_count;
  logic [lrup_pkg::CNT_W-1:0]     hit_count;

  modport source (output valid, output fault, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, output hit_count, input ready);
  modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, input hit_count, output ready);
endinterface

// Config write channel (frames_in_use)
interface lrup_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lrup_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

// File: rtl/lrup_ram.sv
`timescale 1ns / 1ps

// Simple dual port RAM, one write and one registered read per cycle
module lrup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lru_page_replacement_top.sv
`timescale 1ns / 1ps

// LRU page replacement over a fully associative store of FRAMES frames. Each
// input item is one page reference and yields exactly one result item: hit or
// fault, the frame now holding the page, the evicted page if a resident one was
// replaced, and saturating fault/hit totals. Only the first frames_in_use
// frames (0 acts as 1, above FRAMES acts as FRAMES) are searched or replaced;
// the others keep their pages and keep ageing. Each item is accepted, then
// the single page comparator walks the active frames in turn through the
// page RAM's read port (a hit ends the walk early), then the recency/RAM
// update is done, and the result is held until the receiver takes it.
// in_ready is high only when idle. The store comes out of reset empty; no
// clearing pass. frames_in_use resets to 8 and must only be written while
// no item is in flight.
module lru_page_replacement_top #(
  parameter int FRAMES = lrup_pkg::FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  lrup_in_if.sink         in_ch,
  lrup_out_if.source      out_ch,
  lrup_cfg_if.sink        cfg_ch
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW    = $clog2(FRAMES + 1);
  localparam int PB    = lrup_pkg::PAGE_BITS;
  localparam int CW    = lrup_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_OUT
  } state_t;

  // control
  state_t                        state_r, state_nxt;
  logic [IDX_W-1:0]              k_r, k_nxt;
  logic [lrup_pkg::CFG_W-1:0]    fiu_r, fiu_nxt;

  // item being worked on
  logic [PB-1:0]                 page_r, page_nxt;
  logic                          hit_r, hit_nxt;
  logic [IDX_W-1:0]              hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]              hit_rank_r, hit_rank_nxt;
  logic                          emp_r, emp_nxt;
  logic [IDX_W-1:0]              emp_idx_r, emp_idx_nxt;
  logic [IDX_W-1:0]              best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]              best_rank_r, best_rank_nxt;
  logic [PB-1:0]                 best_page_r, best_page_nxt;

  // frame state: valid marks and ages (0 = most recent)
  logic [FRAMES-1:0]             valid_r, valid_nxt;
  logic [IDX_W-1:0]              rank_r [FRAMES];
  logic [IDX_W-1:0]              rank_nxt [FRAMES];

  logic [CW-1:0]                 fault_cnt_r, fault_cnt_nxt;
  logic [CW-1:0]                 hit_cnt_r, hit_cnt_nxt;

  // result register
  logic                          o_fault_r, o_fault_nxt;
  logic [lrup_pkg::IDX_OUT_W-1:0] o_idx_r, o_idx_nxt;
  logic                          o_ev_r, o_ev_nxt;
  logic [PB-1:0]                 o_ev_page_r, o_ev_page_nxt;
  logic [CW-1:0]                 o_fcnt_r, o_fcnt_nxt;
  logic [CW-1:0]                 o_hcnt_r, o_hcnt_nxt;

  // datapath
  logic [NW-1:0]                 n_act;
  logic                          scan_last;
  logic [IDX_W-1:0]              ram_raddr;
  logic [PB-1:0]                 ram_rdata;
  logic                          ram_we;
  logic                          cur_valid;
  logic [IDX_W-1:0]              cur_rank;
  logic                          match;
  logic [IDX_W-1:0]              f_sel;
  logic                          f_was_valid;
  logic [IDX_W-1:0]              f_old_rank;
  logic                          evict;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (fiu_r == '0) begin
      n_act = NW'(1);
    end else if (int'(fiu_r) > FRAMES) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(fiu_r);
    end
  end

  assign scan_last = ((NW'(k_r) + NW'(1)) == n_act);

  // read one frame ahead: k+1 while walking, else address 0
  assign ram_raddr = (state_r == ST_SCAN && !scan_last) ? IDX_W'(k_r + IDX_W'(1)) : '0;
  assign ram_we    = (state_r == ST_UPD);

  lrup_ram #(
    .WIDTH (PB),
    .DEPTH (FRAMES),
    .AW    (IDX_W)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_sel),
    .wdata (page_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the shared comparator: one frame per cycle
  assign cur_valid = valid_r[k_r];
  assign cur_rank  = rank_r[k_r];
  assign match     = cur_valid && (ram_rdata == page_r);

  // frame picked for the update: hit, else first empty, else oldest
  always_comb begin
    if (hit_r) begin
      f_sel       = hit_idx_r;
      f_was_valid = 1'b1;
      f_old_rank  = hit_rank_r;
    end else if (emp_r) begin
      f_sel       = emp_idx_r;
      f_was_valid = 1'b0;
      f_old_rank  = '0;
    end else begin
      f_sel       = best_idx_r;
      f_was_valid = 1'b1;
      f_old_rank  = best_rank_r;
    end
  end

  assign evict = !hit_r && !emp_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    fiu_nxt       = fiu_r;
    page_nxt      = page_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    emp_nxt       = emp_r;
    emp_idx_nxt   = emp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_rank_nxt = best_rank_r;
    best_page_nxt = best_page_r;
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    fault_cnt_nxt = fault_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    o_fault_nxt   = o_fault_r;
    o_idx_nxt     = o_idx_r;
    o_ev_nxt      = o_ev_r;
    o_ev_page_nxt = o_ev_page_r;
    o_fcnt_nxt    = o_fcnt_r;
    o_hcnt_nxt    = o_hcnt_r;

    if (cfg_ch.valid) begin
      fiu_nxt = cfg_ch.frames_in_use;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          page_nxt  = in_ch.page;
          hit_nxt   = 1'b0;
          emp_nxt   = 1'b0;
          k_nxt     = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (match) begin
          // first matching frame wins, walk ends here
          hit_nxt      = 1'b1;
          hit_idx_nxt  = k_r;
          hit_rank_nxt = cur_rank;
          state_nxt    = ST_UPD;
        end else begin
          if (!cur_valid && !emp_r) begin
            emp_nxt     = 1'b1;
            emp_idx_nxt = k_r;
          end
          // strictly older only: ties stay at the lower index
          if (k_r == '0 || cur_rank > best_rank_r) begin
            best_idx_nxt  = k_r;
            best_rank_nxt = cur_rank;
            best_page_nxt = ram_rdata;
          end
          if (scan_last) begin
            state_nxt = ST_UPD;
          end else begin
            k_nxt = IDX_W'(k_r + IDX_W'(1));
          end
        end
      end

      ST_UPD: begin
        // age every valid frame younger than the touched one, or every valid frame if it was empty
        for (int j = 0; j < FRAMES; j++) begin
          if (f_sel == IDX_W'(j)) begin
            rank_nxt[j]  = '0;
            valid_nxt[j] = 1'b1;
          end else if (valid_r[j] && (!f_was_valid || rank_r[j] < f_old_rank)) begin
            rank_nxt[j] = IDX_W'(rank_r[j] + IDX_W'(1));
          end
        end
        if (hit_r) begin
          if (hit_cnt_r != '1) begin
            hit_cnt_nxt = hit_cnt_r + CW'(1);
          end
        end else begin
          if (fault_cnt_r != '1) begin
            fault_cnt_nxt = fault_cnt_r + CW'(1);
          end
        end
        o_fault_nxt   = !hit_r;
        o_idx_nxt     = lrup_pkg::IDX_OUT_W'(f_sel);
        o_ev_nxt      = evict;
        o_ev_page_nxt = evict ? best_page_r : '0;
        o_fcnt_nxt    = fault_cnt_nxt;
        o_hcnt_nxt    = hit_cnt_nxt;
        state_nxt     = ST_OUT;
      end

      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      fiu_r       <= lrup_pkg::FIU_RESET;
      hit_r       <= 1'b0;
      emp_r       <= 1'b0;
      valid_r     <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        rank_r[j] <= '0;
      end
      fault_cnt_r <= '0;
      hit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      fiu_r       <= fiu_nxt;
      hit_r       <= hit_nxt;
      emp_r       <= emp_nxt;
      valid_r     <= valid_nxt;
      rank_r      <= rank_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
    end
    page_r      <= page_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    emp_idx_r   <= emp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rank_r <= best_rank_nxt;
    best_page_r <= best_page_nxt;
    o_fault_r   <= o_fault_nxt;
    o_idx_r     <= o_idx_nxt;
    o_ev_r      <= o_ev_nxt;
    o_ev_page_r <= o_ev_page_nxt;
    o_fcnt_r    <= o_fcnt_nxt;
    o_hcnt_r    <= o_hcnt_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = (state_r == ST_OUT);
  assign out_ch.fault         = o_fault_r;
  assign out_ch.frame_index   = o_idx_r;
  assign out_ch.evicted_valid = o_ev_r;
  assign out_ch.evicted_page  = o_ev_page_r;
  assign out_ch.fault_count   = o_fcnt_r;
  assign out_ch.hit_count     = o_hcnt_r;

`ifndef SYNTHESIS
  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.fault) |-> !out_ch.evicted_valid)
    else $error("hit reported with eviction");

  // the update step moves exactly one total unless it is pinned
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (((fault_cnt_r != $past(fault_cnt_r)) !=
      (hit_cnt_r != $past(hit_cnt_r))) || $past(&fault_cnt_r) || $past(&hit_cnt_r)))
    else $error("fault/hit totals out of step");

  // the chosen frame is one of the active ones
  a_frame_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (NW'(f_sel) < n_act))
    else $error("frame outside active set");

  // an accepted item blocks the input until its result is delivered
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while busy");

  // touched frame is marked resident and most recent
  a_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (valid_r[$past(f_sel)] && rank_r[$past(f_sel)] == '0))
    else $error("touched frame not most recent");
`endif

endmodule

// File: tb/lru_page_replacement_top_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;

  localparam int PAGE_BITS = lrup_pkg::PAGE_BITS;
  localparam int IDX_OUT_W = lrup_pkg::IDX_OUT_W;
  localparam int CNT_W     = lrup_pkg::CNT_W;
  localparam int CFG_W     = lrup_pkg::CFG_W;
  localparam logic [CFG_W-1:0] FIU_RESET = lrup_pkg::FIU_RESET;

  localparam int N_FRAMES    = lrup_pkg::FRAMES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD   = 600;      // one long result-side stall
  localparam int HOLD_AT     = 300;      // ...started after this many results

  // One result item as the block reports it
  typedef struct packed {
    logic                 fault;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     fault_count;
    logic [CNT_W-1:0]     hit_count;
  } page_verdict_t;

  // Directed steps: access checked by the predictor, access with a typed
  // expectation, or a frames_in_use write
  typedef enum bit [1:0] {DO_ACCESS, DO_CHECKED, DO_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [PAGE_BITS-1:0] page;
    logic [CFG_W-1:0]     fiu;
    page_verdict_t        want;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lrup_in_if  in_ch ();
  lrup_out_if out_ch ();
  lrup_cfg_if cfg_ch ();

  lru_page_replacement_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the frame store, ages and totals.
  // age 0 = most recent; valid frames hold distinct ages below N_FRAMES.
  // ---------------------------------------------------------------------------
  logic [PAGE_BITS-1:0] tag_mem [N_FRAMES];
  bit                   live    [N_FRAMES];
  int                   age     [N_FRAMES];
  logic [CNT_W-1:0]     faults_sum;
  logic [CNT_W-1:0]     hits_sum;
  logic [CFG_W-1:0]     fiu_shadow;

  page_verdict_t verdict_q [$];   // results still owed by the block
  int            mismatches = 0;
  bit            burst = 1'b0;    // sender offers back to back when set
  longint        cycle_cnt = 0;

  function automatic page_verdict_t lru_access(logic [PAGE_BITS-1:0] p);
    page_verdict_t v;
    int n;
    int f;
    int old;
    bit hit;
    bit empty_found;
    // 0 behaves as one frame, anything past the store as the whole store
    n = (fiu_shadow == 0) ? 1 : ((fiu_shadow > N_FRAMES) ? N_FRAMES : int'(fiu_shadow));
    v = '0;
    f = 0;
    hit = 1'b0;
    empty_found = 1'b0;
    for (int k = 0; k < n; k++)
      if (!hit && live[k] && tag_mem[k] == p) begin
        f = k;
        hit = 1'b1;
      end
    if (!hit) begin
      for (int k = 0; k < n; k++)
        if (!empty_found && !live[k]) begin
          f = k;
          empty_found = 1'b1;
        end
      if (!empty_found) begin
        // oldest frame in use; strict compare keeps ties on the lowest index
        f = 0;
        for (int k = 1; k < n; k++)
          if (age[k] > age[f]) f = k;
        v.evicted_valid = 1'b1;
        v.evicted_page  = tag_mem[f];
      end
      if (faults_sum != '1) faults_sum++;
    end else if (hits_sum != '1) begin
      hits_sum++;
    end
    // ageing covers every valid frame, including those outside the active set
    old = live[f] ? age[f] : N_FRAMES;
    for (int k = 0; k < N_FRAMES; k++)
      if (k != f && live[k] && age[k] < old) age[k]++;
    age[f]     = 0;
    tag_mem[f] = p;
    live[f]    = 1'b1;
    v.fault       = !hit;
    v.frame_index = IDX_OUT_W'(f);
    v.fault_count = faults_sum;
    v.hit_count   = hits_sum;
    return v;
  endfunction

  // Table row builders
  function automatic dir_step_t acc(logic [PAGE_BITS-1:0] p);
    dir_step_t s;
    s = '0;
    s.kind = DO_ACCESS;
    s.page = p;
    return s;
  endfunction

  // Access with no eviction and a known outcome
  function automatic dir_step_t chk(logic [PAGE_BITS-1:0] p, logic flt,
                                    logic [IDX_OUT_W-1:0] idx, int fc, int hc);
    dir_step_t s;
    s = '0;
    s.kind = DO_CHECKED;
    s.page = p;
    s.want.fault       = flt;
    s.want.frame_index = idx;
    s.want.fault_count = CNT_W'(fc);
    s.want.hit_count   = CNT_W'(hc);
    return s;
  endfunction

  function automatic dir_step_t set_fiu(logic [CFG_W-1:0] v);
    dir_step_t s;
    s = '0;
    s.kind = DO_CONFIG;
    s.fiu  = v;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Page reference sender. Inputs change only by NBA at the rising edge;
  // valid stays high across back-to-back items (gap 0).
  // ---------------------------------------------------------------------------
  task automatic send_page(input logic [PAGE_BITS-1:0] p, input bit typed,
                           input page_verdict_t want);
    int gap;
    page_verdict_t v;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.page  <= p;
    do @(posedge clk); while (!in_ch.ready);
    // predictor always runs so its state follows the block
    v = lru_access(p);
    verdict_q.push_back(typed ? want : v);
  endtask

  // Block goes idle once every result is out; one item per accept, so the
  // short pause is only a margin for the return to idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fiu(input logic [CFG_W-1:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.frames_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fiu_shadow = v;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_step_t            steps [23];
    int                   phase_fiu [11];
    logic [PAGE_BITS-1:0] pool [12];
    int                   pool_n;
    int                   eff;
    int                   pick;
    logic [PAGE_BITS-1:0] p;

    // Directed part. Typed rows: fresh store at reset, all-zero and all-ones
    // pages filling frames 0/1, then hits on both. The rest fills the store,
    // forces LRU eviction, shrinks the frame set (pages left behind in upper
    // frames miss again and go resident twice), runs with 0 frames (acts as
    // one) and with an oversize count (acts as all eight).
    steps = '{
      chk(16'h0000, 1'b1, 3'd0, 1, 0),
      chk(16'hFFFF, 1'b1, 3'd1, 2, 0),
      chk(16'h0000, 1'b0, 3'd0, 2, 1),
      chk(16'hFFFF, 1'b0, 3'd1, 2, 2),
      acc(16'h0001), acc(16'h0002), acc(16'h0003),
      acc(16'h0004), acc(16'h0005), acc(16'h0006),
      acc(16'h0007),                      // store full: evicts page 0
      acc(16'h5555),
      set_fiu(4'd2),
      acc(16'hAAAA),
      acc(16'h0003),                      // lives in frame 4 only: misses
      set_fiu(4'd0),
      acc(16'h8000),
      acc(16'h8000),
      acc(16'h0001),
      set_fiu(4'd15),
      acc(16'h0003),
      acc(16'h7FFF),
      set_fiu(FIU_RESET)
    };
    // Random phases walk the frame count from 0 up to 15, covering every active count 1..8
    phase_fiu = '{1, 8, 3, 0, 12, 5, 2, 15, 7, 4, 6};

    for (int k = 0; k < N_FRAMES; k++) begin
      tag_mem[k] = '0;
      live[k]    = 1'b0;
      age[k]     = 0;
    end
    faults_sum = '0;
    hits_sum   = '0;
    fiu_shadow = FIU_RESET;

    in_ch.valid          = 1'b0;
    in_ch.page           = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.frames_in_use = FIU_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      case (steps[i].kind)
        DO_CONFIG: begin
          drain();
          write_fiu(steps[i].fiu);
        end
        DO_CHECKED: send_page(steps[i].page, 1'b1, steps[i].want);
        default:    send_page(steps[i].page, 1'b0, '0);
      endcase
    end

    // Random part: mostly references to a small working set sized around the
    // active frame count (hits, refills, evictions), some low page numbers,
    // and some fully random pages for bit coverage.
    foreach (phase_fiu[ph]) begin
      drain();
      write_fiu(CFG_W'(phase_fiu[ph]));
      eff = (phase_fiu[ph] == 0) ? 1 : ((phase_fiu[ph] > N_FRAMES) ? N_FRAMES : phase_fiu[ph]);
      pool_n = eff + $urandom_range(0, 3);
      for (int k = 0; k < pool_n; k++) pool[k] = PAGE_BITS'($urandom);
      burst = ($urandom_range(0, 3) == 0);
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          p = pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 8)
          p = PAGE_BITS'($urandom_range(0, 15));
        else
          p = PAGE_BITS'($urandom);
        send_page(p, 1'b0, '0);
      end
    end
    burst = 1'b0;

    // Let the tail drain, then a short quiet window for stray results
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("lru_page_replacement_top verification clean");
    end else begin
      $display("lru_page_replacement_top verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per item, calm stretches with none, and
  // one long hold-off so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin
    int  stall;
    int  taken;
    bit  calm;
    bit  held;
    out_ch.ready = 1'b0;
    taken = 0;
    calm  = 1'b0;
    held  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 19);
      if (taken == HOLD_AT && !held) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: in-order compare against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    page_verdict_t got;
    page_verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.fault         = out_ch.fault;
      got.frame_index   = out_ch.frame_index;
      got.evicted_valid = out_ch.evicted_valid;
      got.evicted_page  = out_ch.evicted_page;
      got.fault_count   = out_ch.fault_count;
      got.hit_count     = out_ch.hit_count;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: fault=%0b frame=%0d ev=%0b/%h fc=%0d hc=%0d",
                   $time, got.fault, got.frame_index, got.evicted_valid,
                   got.evicted_page, got.fault_count, got.hit_count);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result mismatch: exp fault=%0b frame=%0d ev=%0b/%h fc=%0d hc=%0d",
                      " | got fault=%0b frame=%0d ev=%0b/%h fc=%0d hc=%0d"},
                     $time, want.fault, want.frame_index, want.evicted_valid,
                     want.evicted_page, want.fault_count, want.hit_count,
                     got.fault, got.frame_index, got.evicted_valid,
                     got.evicted_page, got.fault_count, got.hit_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lru_page_replacement_top verification failed");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/lrup_pkg.sv
rtl/lrup_if.sv
rtl/lrup_ram.sv
rtl/lru_page_replacement_top.sv
tb/lru_page_replacement_top_tb.sv
